@@ design/bmm_pkg.sv @@
// Shared types, constants and helpers for the RGB blend mode mixer.
package bmm_pkg;

	// channel and input widths
	localparam int CHAN_W  = 8;
	localparam int ALPHA_W = 7;
	localparam int MODE_W  = 3;
	localparam int IN_W    = 6 * CHAN_W;
	localparam int OUT_W   = 3 * CHAN_W;
	localparam int LANES   = 3;

	// pipeline depth of one lane (input register up to output register)
	localparam int NST = 8;

	// configuration register indexes
	localparam logic CFG_REG_MODE  = 1'b0;
	localparam logic CFG_REG_ALPHA = 1'b1;

	// blend modes
	localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LIGHTEN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DARKEN  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BURN    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ADD     = 3'd5;

	localparam logic [CHAN_W-1:0]  CHAN_MAX = 8'd255;
	localparam logic [ALPHA_W-1:0] PCT_FULL = 7'd100;

	// floor(x/100) for x <= 25500 is (x * 5243) >> 19
	localparam int              RECIP_W     = 13;
	localparam logic [12:0]     RECIP_100   = 13'd5243;
	localparam int              RECIP_SHIFT = 19;
	localparam int              SUM_W       = 15;
	localparam int              PROD_W      = SUM_W + RECIP_W;

	// settled configuration as seen by the lanes
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ALPHA_W-1:0] alpha;     // saturated to 100
		logic [ALPHA_W-1:0] alpha_inv; // 100 - alpha
	} cfg_t;

	// stage advance enables from the flow control
	typedef struct packed {
		logic [NST-1:0] en;
	} flow_t;

	// partial remainder and quotient of the burn divider
	typedef struct packed {
		logic [15:0]       rem;
		logic [CHAN_W-1:0] quo;
	} div_t;

	// one restoring division step: quotient bit at position pos
	function automatic div_t div_step(input div_t d, input logic [CHAN_W-1:0] b,
			input int pos);
		logic [15:0] sub;
		div_t        r;
		sub = {8'h00, b} << pos;
		r   = d;
		if (d.rem >= sub) begin
			r.rem      = d.rem - sub;
			r.quo[pos] = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ design/rgb_blend_mode_mixer_unit.sv @@
// Top level of the RGB blend mode mixer: config registers, three lanes, output packing.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: fg r,g,b, bg r,g,b (8 bits each)
//  m_axis    out  tvalid/tready           tdata: out r,g,b (8 bits each)
//  cfg       in   cfg_we                  cfg_addr selects register, cfg_wdata
//
// One pixel per clock cycle sustained while m_axis_tready is high; a lane holds a
// four-stage burn divider plus weighting, sum and reciprocal multiply stages.
// Reset clears the valid bits and sets mode normal, opacity 100 percent.
// An output stall holds only the stages that are full; empty stages upstream
// keep taking pixels until the pipeline is packed.
module rgb_blend_mode_mixer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue from bit 0 up
	input  logic [bmm_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_red, out_green, out_blue from bit 0 up
	output logic [bmm_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        cfg_we,
	input  logic                        cfg_addr,
	input  logic [bmm_pkg::ALPHA_W-1:0] cfg_wdata
);
	import bmm_pkg::*;

	logic [MODE_W-1:0]  mode_q;
	logic [ALPHA_W-1:0] alpha_q;
	cfg_t               cfg;
	flow_t              flow;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			alpha_q <= PCT_FULL;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_REG_MODE:  mode_q  <= cfg_wdata[MODE_W-1:0];
				CFG_REG_ALPHA: alpha_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// opacity above 100 saturates
	always_comb begin
		cfg.mode      = mode_q;
		cfg.alpha     = (alpha_q > PCT_FULL) ? PCT_FULL : alpha_q;
		cfg.alpha_inv = PCT_FULL - cfg.alpha;
	end

	bmm_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.flow      (flow)
	);

	// one lane per colour; results packed red first
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		bmm_lane u_lane (
			.clk   (clk),
			.flow  (flow),
			.cfg   (cfg),
			.fg    (s_axis_tdata[l*CHAN_W +: CHAN_W]),
			.bg    (s_axis_tdata[(l+LANES)*CHAN_W +: CHAN_W]),
			.mixed (m_axis_tdata[l*CHAN_W +: CHAN_W])
		);
	end

endmodule

@@ design/bmm_flow.sv @@
// Valid tracking and stage enables for the lane pipeline, with bubble collapse.
module bmm_flow (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bmm_pkg::flow_t  flow
);
	import bmm_pkg::*;

	logic [NST-1:0] v_q;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		flow.en[NST-1] = !v_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			flow.en[k] = !v_q[k] || flow.en[k+1];
		end
	end

	assign in_ready  = flow.en[0];
	assign out_valid = v_q[NST-1];

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (flow.en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (flow.en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

endmodule

@@ design/bmm_lane.sv @@
// One colour channel: blend function, burn divider, alpha mix and divide by 100.
module bmm_lane (
	input  logic                       clk,
	input  bmm_pkg::flow_t             flow,
	input  bmm_pkg::cfg_t              cfg,
	input  logic [bmm_pkg::CHAN_W-1:0] fg,
	input  logic [bmm_pkg::CHAN_W-1:0] bg,
	output logic [bmm_pkg::CHAN_W-1:0] mixed
);
	import bmm_pkg::*;

	logic [CHAN_W-1:0] fsim;
	logic [8:0]        sum9;
	logic [15:0]       num;
	logic [15:0]       lim;
	div_t              d_in, d2, d3, d4, d5;
	logic [CHAN_W-1:0] f_sel;

	logic [CHAN_W-1:0] fsim_s1, fsim_s2, fsim_s3, fsim_s4, fsim_s5;
	logic [CHAN_W-1:0] b_s1, b_s2, b_s3, b_s4, b_s5;
	logic              burn_s1, burn_s2, burn_s3, burn_s4, burn_s5;
	logic              ovf_s1, ovf_s2, ovf_s3, ovf_s4, ovf_s5;
	div_t              div_s1, div_s2, div_s3, div_s4, div_s5;
	logic [SUM_W-1:0]  pf_s6, pb_s6;
	logic [SUM_W-1:0]  sum_s7;
	logic [PROD_W-1:0] prod_s8;

	// blend value for every mode but burn
	always_comb begin
		sum9 = {1'b0, fg} + {1'b0, bg};
		case (cfg.mode)
			MODE_LIGHTEN: fsim = (fg > bg) ? fg : bg;
			MODE_DARKEN:  fsim = (fg < bg) ? fg : bg;
			MODE_AVERAGE: fsim = sum9[8:1];
			MODE_ADD:     fsim = sum9[8] ? CHAN_MAX : sum9[7:0];
			default:      fsim = fg;
		endcase
	end

	// burn numerator (255-A)*256; quotient saturates when it reaches 255*B,
	// which also covers a zero background
	assign num      = {~fg, 8'h00};
	assign lim      = {bg, 8'h00} - {8'h00, bg};
	assign d_in.rem = num;
	assign d_in.quo = '0;

	// two quotient bits per stage, most significant first
	assign d2 = div_step(div_step(div_s1, b_s1, 7), b_s1, 6);
	assign d3 = div_step(div_step(div_s2, b_s2, 5), b_s2, 4);
	assign d4 = div_step(div_step(div_s3, b_s3, 3), b_s3, 2);
	assign d5 = div_step(div_step(div_s4, b_s4, 1), b_s4, 0);

	// final blend value
	always_comb begin
		if (!burn_s5) begin
			f_sel = fsim_s5;
		end else if (ovf_s5) begin
			f_sel = '0;
		end else begin
			f_sel = CHAN_MAX - div_s5.quo;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: capture, simple modes, burn set-up
		if (flow.en[0]) begin
			fsim_s1 <= fsim;
			b_s1    <= bg;
			burn_s1 <= (cfg.mode == MODE_BURN);
			ovf_s1  <= (num >= lim);
			div_s1  <= d_in;
		end
		// stages 2 to 5: burn divider
		if (flow.en[1]) begin
			fsim_s2 <= fsim_s1;
			b_s2    <= b_s1;
			burn_s2 <= burn_s1;
			ovf_s2  <= ovf_s1;
			div_s2  <= d2;
		end
		if (flow.en[2]) begin
			fsim_s3 <= fsim_s2;
			b_s3    <= b_s2;
			burn_s3 <= burn_s2;
			ovf_s3  <= ovf_s2;
			div_s3  <= d3;
		end
		if (flow.en[3]) begin
			fsim_s4 <= fsim_s3;
			b_s4    <= b_s3;
			burn_s4 <= burn_s3;
			ovf_s4  <= ovf_s3;
			div_s4  <= d4;
		end
		if (flow.en[4]) begin
			fsim_s5 <= fsim_s4;
			b_s5    <= b_s4;
			burn_s5 <= burn_s4;
			ovf_s5  <= ovf_s4;
			div_s5  <= d5;
		end
		// stage 6: weight blend value and background
		if (flow.en[5]) begin
			pf_s6 <= SUM_W'(cfg.alpha) * SUM_W'(f_sel);
			pb_s6 <= SUM_W'(cfg.alpha_inv) * SUM_W'(b_s5);
		end
		// stage 7: weighted sum, at most 25500
		if (flow.en[6]) begin
			sum_s7 <= pf_s6 + pb_s6;
		end
		// stage 8: reciprocal multiply for the divide by 100
		if (flow.en[7]) begin
			prod_s8 <= PROD_W'(sum_s7) * PROD_W'(RECIP_100);
		end
	end

	assign mixed = prod_s8[RECIP_SHIFT +: CHAN_W];

endmodule

@@ tb/sv/rgb_blend_mode_mixer_unit_tb.sv @@
// Self-checking testbench for the RGB blend mode mixer: directed table, random phases, stalls.
`timescale 1ns / 1ps

module rgb_blend_mode_mixer_unit_tb;
	import bmm_pkg::*;

	// packed so that bit 0 holds the first field of the stream word
	typedef struct packed {
		logic [CHAN_W-1:0] bg_blue;
		logic [CHAN_W-1:0] bg_green;
		logic [CHAN_W-1:0] bg_red;
		logic [CHAN_W-1:0] fg_blue;
		logic [CHAN_W-1:0] fg_green;
		logic [CHAN_W-1:0] fg_red;
	} layer_pair_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	// one directed row: register values, pixels, and a typed result where obvious
	typedef struct packed {
		logic [ALPHA_W-1:0] mode_wr;
		logic [ALPHA_W-1:0] alpha_wr;
		logic [CHAN_W-1:0]  fg_r, fg_g, fg_b;
		logic [CHAN_W-1:0]  bg_r, bg_g, bg_b;
		logic               typed;
		logic [CHAN_W-1:0]  ex_r, ex_g, ex_b;
	} blend_row_t;

	localparam int N_ROWS = 20;
	localparam blend_row_t DIRECTED_ROWS [N_ROWS] = '{
		// reset settings: normal, full opacity
		'{7'd0,   7'd100, 8'hFF, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56, 1'b1, 8'hFF, 8'h00, 8'h80},
		'{7'd0,   7'd100, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
		// lighten and darken
		'{7'd1,   7'd100, 8'h10, 8'hF0, 8'h00, 8'h20, 8'hE0, 8'hFF, 1'b1, 8'h20, 8'hF0, 8'hFF},
		'{7'd2,   7'd100, 8'h10, 8'hF0, 8'h00, 8'h20, 8'hE0, 8'hFF, 1'b1, 8'h10, 8'hE0, 8'h00},
		// colour burn over a black background gives black
		'{7'd3,   7'd100, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
		'{7'd3,   7'd100, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h01, 1'b1, 8'hFF, 8'h00, 8'h00},
		'{7'd3,   7'd100, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 1'b1, 8'h00, 8'h00, 8'h00},
		// average rounds down, add saturates
		'{7'd4,   7'd100, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h02, 1'b1, 8'hFF, 8'h00, 8'h01},
		'{7'd5,   7'd100, 8'hFF, 8'h80, 8'h01, 8'hFF, 8'h80, 8'h02, 1'b1, 8'hFF, 8'hFF, 8'h03},
		// unused mode codes behave as normal
		'{7'd6,   7'd100, 8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF, 1'b1, 8'h12, 8'h34, 8'h56},
		'{7'd7,   7'd100, 8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF, 1'b1, 8'h12, 8'h34, 8'h56},
		// zero opacity passes the background
		'{7'd5,   7'd0,   8'hFF, 8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33, 1'b1, 8'h11, 8'h22, 8'h33},
		// opacity above 100 saturates, followed by a half-opacity row
		'{7'd0,   7'd127, 8'h5A, 8'hA5, 8'h3C, 8'h00, 8'h00, 8'h00, 1'b1, 8'h5A, 8'hA5, 8'h3C},
		'{7'd0,   7'd101, 8'h5A, 8'hA5, 8'h3C, 8'h00, 8'h00, 8'h00, 1'b1, 8'h5A, 8'hA5, 8'h3C},
		'{7'd0,   7'd50,  8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1, 8'h7F, 8'h7F, 8'hFF},
		// partial opacity, checked by the predictor
		'{7'd3,   7'd1,   8'h9C, 8'h40, 8'hF7, 8'h3D, 8'hC8, 8'h05, 1'b0, 8'h00, 8'h00, 8'h00},
		'{7'd1,   7'd99,  8'h7E, 8'h81, 8'h01, 8'hFE, 8'h80, 8'h02, 1'b0, 8'h00, 8'h00, 8'h00},
		'{7'd2,   7'd37,  8'hC3, 8'h3C, 8'hAA, 8'h55, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{7'd4,   7'd63,  8'hFE, 8'h01, 8'h77, 8'h01, 8'hFE, 8'h88, 1'b0, 8'h00, 8'h00, 8'h00},
		// upper write bits of the mode register are dropped
		'{7'h7B,  7'd100, 8'h40, 8'hC0, 8'hFF, 8'h80, 8'h40, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00}
	};

	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 75;
	localparam int HOLD_CYCLES = 60;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               cfg_we        = 1'b0;
	logic               cfg_addr      = CFG_REG_MODE;
	logic [ALPHA_W-1:0] cfg_wdata     = '0;

	// predictor copy of the registers
	logic [MODE_W-1:0]  cur_mode  = MODE_NORMAL;
	logic [ALPHA_W-1:0] cur_alpha = PCT_FULL;
	logic [ALPHA_W-1:0] wr_mode   = '0;
	logic [ALPHA_W-1:0] wr_alpha  = PCT_FULL;

	rgb_t expected_pixels [$];
	int   fault_count = 0;
	int   rx_count    = 0;
	bit   tx_burst    = 1'b0;
	bit   rx_burst    = 1'b0;

	rgb_blend_mode_mixer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// blend one channel and weight it over the background
	function automatic logic [CHAN_W-1:0] blend_channel(input int a, input int b);
		int f;
		int q;
		int op;
		op = (cur_alpha > PCT_FULL) ? 100 : int'(cur_alpha);
		case (cur_mode)
			MODE_LIGHTEN: f = (a > b) ? a : b;
			MODE_DARKEN:  f = (a < b) ? a : b;
			MODE_BURN: begin
				if (b == 0) begin
					f = 0;
				end else begin
					q = ((255 - a) * 256) / b;
					f = (q >= 255) ? 0 : 255 - q;
				end
			end
			MODE_AVERAGE: f = (a + b) / 2;
			MODE_ADD:     f = (a + b > 255) ? 255 : a + b;
			default:      f = a;
		endcase
		return CHAN_W'((op * f + (100 - op) * b) / 100);
	endfunction

	function automatic rgb_t blended_pixel(input layer_pair_t px);
		rgb_t r;
		r.red   = blend_channel(int'(px.fg_red), int'(px.bg_red));
		r.green = blend_channel(int'(px.fg_green), int'(px.bg_green));
		r.blue  = blend_channel(int'(px.fg_blue), int'(px.bg_blue));
		return r;
	endfunction

	// channel values biased towards the extremes
	function automatic logic [CHAN_W-1:0] pick_chan();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h01;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	// register writes, only issued with the pipeline empty
	task automatic load_settings(input logic [ALPHA_W-1:0] mode_v,
			input logic [ALPHA_W-1:0] alpha_v);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_REG_MODE;
		cfg_wdata <= mode_v;
		@(posedge clk);
		cfg_addr  <= CFG_REG_ALPHA;
		cfg_wdata <= alpha_v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		wr_mode   = mode_v;
		wr_alpha  = alpha_v;
		cur_mode  = mode_v[MODE_W-1:0];
		cur_alpha = alpha_v;
	endtask

	// stop offering, wait for every outstanding result, then let the pipe settle
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (NST + 2) @(posedge clk);
	endtask

	// offer one pixel pair; the expectation is queued at the accepting edge
	task automatic send_pixel(input layer_pair_t px, input rgb_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_pixels.push_back(want);
	endtask

	task automatic check_result(input rgb_t got);
		rgb_t want;
		if (expected_pixels.size() == 0) begin
			$error("unexpected output transaction: %h", got);
			fault_count++;
		end else begin
			want = expected_pixels.pop_front();
			if (got.red !== want.red) begin
				$error("out_red: expected %0d, got %0d", want.red, got.red);
				fault_count++;
			end
			if (got.green !== want.green) begin
				$error("out_green: expected %0d, got %0d", want.green, got.green);
				fault_count++;
			end
			if (got.blue !== want.blue) begin
				$error("out_blue: expected %0d, got %0d", want.blue, got.blue);
				fault_count++;
			end
		end
	endtask

	// output side: random stalls, two long hold-offs to back the pipe up
	initial begin : result_sink
		int hold;
		// no sampling until the valid bits have been cleared
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = rx_burst ? 0 : $urandom_range(0, 4);
			if (rx_count == 200 || rx_count == 500)
				hold = HOLD_CYCLES;
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			check_result(m_axis_tdata);
			rx_count++;
			if (rx_count % 64 == 0)
				rx_burst = ($urandom_range(0, 2) == 0);
		end
	end

	// main stimulus
	initial begin : stimulus
		layer_pair_t        px;
		rgb_t               want;
		blend_row_t         row;
		logic [ALPHA_W-1:0] mode_v;
		logic [ALPHA_W-1:0] alpha_v;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_ROWS; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.mode_wr != wr_mode || row.alpha_wr != wr_alpha) begin
				drain_pipe();
				load_settings(row.mode_wr, row.alpha_wr);
			end
			px.fg_red   = row.fg_r;
			px.fg_green = row.fg_g;
			px.fg_blue  = row.fg_b;
			px.bg_red   = row.bg_r;
			px.bg_green = row.bg_g;
			px.bg_blue  = row.bg_b;
			if (row.typed) begin
				want.red   = row.ex_r;
				want.green = row.ex_g;
				want.blue  = row.ex_b;
			end else begin
				want = blended_pixel(px);
			end
			send_pixel(px, want);
		end

		// random phases, each with fresh settings
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_pipe();
			mode_v = ALPHA_W'($urandom_range(0, 127));
			case ($urandom_range(0, 5))
				0:       alpha_v = '0;
				1:       alpha_v = PCT_FULL;
				2:       alpha_v = 7'd127;
				3:       alpha_v = ALPHA_W'($urandom_range(101, 126));
				default: alpha_v = ALPHA_W'($urandom_range(0, 127));
			endcase
			load_settings(mode_v, alpha_v);
			tx_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				px.fg_red   = pick_chan();
				px.fg_green = pick_chan();
				px.fg_blue  = pick_chan();
				px.bg_red   = pick_chan();
				px.bg_green = pick_chan();
				px.bg_blue  = pick_chan();
				send_pixel(px, blended_pixel(px));
			end
		end

		drain_pipe();
		repeat (NST * 2) @(posedge clk);
		if (fault_count == 0)
			$display("** rgb_blend_mode_mixer_unit: PASSED **");
		else
			$display("** rgb_blend_mode_mixer_unit: FAILED **");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#2_000_000;
		$display("** rgb_blend_mode_mixer_unit: FAILED **");
		$finish;
	end

endmodule
